[rtl/dls_pkg.sv]
// ----------------------------------------------------------------------------
// dls_pkg: shared types and constants for the dense layer block
// Word formats of both channels, register indexes, sizing constants and
// the helper that clamps a configured layer size.
// ----------------------------------------------------------------------------
package dls_pkg;

  localparam int MAX_NODES     = 16;
  localparam int NUM_LAYERS    = 4;
  localparam int DATA_WIDTH    = 16;
  localparam int TAYLOR_TERMS  = 64;

  localparam int IDX_W   = $clog2(MAX_NODES);
  localparam int LAYER_W = $clog2(NUM_LAYERS);
  localparam int CNT_W   = IDX_W + 1;
  localparam int WADDR_W = LAYER_W + 2 * IDX_W;
  localparam int WMEM_DEPTH = NUM_LAYERS * MAX_NODES * MAX_NODES;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SIZE0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS0 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS1 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS2 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS3 = 3'd7;

  localparam logic FUNC_WEIGHT = 1'b0;
  localparam logic FUNC_INPUT  = 1'b1;

  typedef struct packed {
    logic                         func;
    logic [1:0]                   layer;
    logic [3:0]                   src_index;
    logic [3:0]                   node_index;
    logic signed [DATA_WIDTH-1:0] value;
    logic                         last;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  node;
    logic [12:0] activation;
    logic        last_out;
    logic        error;
  } out_word_t;

  function automatic logic [CNT_W-1:0] eff_size(input logic [4:0] s);
    logic [CNT_W-1:0] r;
    if (s == 5'd0) begin
      r = CNT_W'(1);
    end else if (s > 5'(MAX_NODES)) begin
      r = CNT_W'(MAX_NODES);
    end else begin
      r = CNT_W'(s);
    end
    return r;
  endfunction

endpackage

[rtl/dense_layer_sigmoid_top.sv]
// ----------------------------------------------------------------------------
// dense_layer_sigmoid_top: fully connected layer with sigmoid output
// Usage:
//   in_valid/in_stall carries one in_data word. func selects a weight write
//   (stored at layer/src_index/node_index) or an input activation,
//   appended to the input buffer. An activation with last set computes the
//   layer: one out_data word per node, node 0 first, last_out on the final.
//   A bad input count or overflow gives one word with error set instead.
//   cfg_we/cfg_index/cfg_wdata write layer sizes and biases; the user must
//   write them only while idle, as the block does not enforce it.
// Each node accumulates its C inputs, then sums series terms until one is
//   zero or the last is done; time is set by the shared 23x17 multiplier and
//   the one-bit-per-cycle restoring divider for every term and final quotient.
// in_stall is low only in the idle state; load words and weight writes are
// taken there. The result register holds a word while out_stall is high
// and the next node keeps computing; it waits only to load the next word.
// Reset (rst_n low, synchronous) restores sizes of 16, zero biases, an
// empty input buffer and no pending result; memories are not cleared.
// ----------------------------------------------------------------------------
module dense_layer_sigmoid_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  dls_pkg::in_word_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output dls_pkg::out_word_t                  out_data,
  input  logic                                cfg_we,
  input  logic [dls_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dls_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import dls_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE = 15'h0001,
    S_MRD  = 15'h0002,
    S_MMUL = 15'h0004,
    S_MACC = 15'h0008,
    S_RND  = 15'h0010,
    S_TLO  = 15'h0020,
    S_THI  = 15'h0040,
    S_TLD  = 15'h0080,
    S_TDIV = 15'h0100,
    S_TUPD = 15'h0200,
    S_FDEN = 15'h0400,
    S_FLD  = 15'h0800,
    S_FDIV = 15'h1000,
    S_EMIT = 15'h2000,
    S_ERR  = 15'h4000
  } state_t;

  localparam logic [5:0] LAST_TERM = 6'(TAYLOR_TERMS - 1);

  state_t state_r, state_nxt;

  logic [4:0]        size0_r, size1_r, size2_r, size3_r;
  logic signed [15:0] bias0_r, bias1_r, bias2_r, bias3_r;

  logic signed [DATA_WIDTH-1:0] wmem [WMEM_DEPTH];
  logic signed [DATA_WIDTH-1:0] ibuf [MAX_NODES];

  logic [CNT_W-1:0]   cnt_r, mcnt_r, nsz_r;
  logic               ovf_r;
  logic [LAYER_W-1:0] layer_r;
  logic signed [15:0] bias_l_r;
  logic [IDX_W-1:0]   j_r, node_i_r;
  logic signed [DATA_WIDTH-1:0] wt_rd_r, in_rd_r;
  logic signed [39:0] prod_r;
  logic signed [37:0] acc_r;
  logic [15:0]        t_r;
  logic               neg_r;
  logic [43:0]        term_r, e_r;
  logic [5:0]         n_r;
  logic [37:0]        big_r;
  logic [44:0]        dvs_r, rem_r;
  logic [43:0]        dsh_r, quo_r;
  logic [5:0]         dcnt_r;
  logic               out_valid_r;
  out_word_t          out_data_r;

  // layer selection and input-count check
  logic [4:0]         sel_size, sel_prev;
  logic signed [15:0] sel_bias;
  logic [CNT_W-1:0]   cnt_app;
  logic               ovf_new, bad;
  logic               in_acc, out_free;

  always_comb begin
    case (in_data.layer)
      2'd0: begin
        sel_size = size0_r; sel_prev = size3_r; sel_bias = bias0_r;
      end
      2'd1: begin
        sel_size = size1_r; sel_prev = size0_r; sel_bias = bias1_r;
      end
      2'd2: begin
        sel_size = size2_r; sel_prev = size1_r; sel_bias = bias2_r;
      end
      default: begin
        sel_size = size3_r; sel_prev = size2_r; sel_bias = bias3_r;
      end
    endcase
  end

  assign in_acc   = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign cnt_app  = (cnt_r < CNT_W'(MAX_NODES)) ? cnt_r + CNT_W'(1) : cnt_r;
  assign ovf_new  = ovf_r || (cnt_r == CNT_W'(MAX_NODES));
  assign bad      = ovf_new || ((in_data.layer != 2'd0) && (cnt_app != eff_size(sel_prev)));

  // shared multiplier
  logic signed [22:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [39:0] mul_p;

  always_comb begin
    case (state_r)
      S_TLO: begin
        mul_a = $signed({1'b0, term_r[21:0]});
        mul_b = $signed({1'b0, t_r});
      end
      S_THI: begin
        mul_a = $signed({1'b0, term_r[43:22]});
        mul_b = $signed({1'b0, t_r});
      end
      default: begin
        mul_a = 23'(wt_rd_r);
        mul_b = 17'(in_rd_r);
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // rounding and saturation to Q4.12
  logic signed [37:0] acc_rnd;
  logic signed [25:0] acc_sh;
  logic signed [15:0] x_sat;
  logic signed [16:0] x_ext, x_mag;

  assign acc_rnd = acc_r + 38'sd2048;
  assign acc_sh  = 26'(acc_rnd >>> 12);

  always_comb begin
    if (acc_sh > 26'sd32767) begin
      x_sat = 16'sh7fff;
    end else if (acc_sh < -26'sd32768) begin
      x_sat = -16'sd32768;
    end else begin
      x_sat = 16'(acc_sh);
    end
  end

  assign x_ext = 17'(x_sat);
  assign x_mag = x_sat[15] ? -x_ext : x_ext;

  // shared restoring divider step
  logic [46:0] div_diff;
  logic        div_ge;
  logic [59:0] tsum;
  logic [56:0] fnum, fnd;

  assign div_diff = {1'b0, rem_r, dsh_r[43]} - {2'b0, dvs_r};
  assign div_ge   = !div_diff[46];
  assign tsum     = {22'b0, big_r} + {prod_r[37:0], 22'b0};
  assign fnum     = neg_r ? (57'd1 << 44) : {1'b0, e_r, 12'b0};
  assign fnd      = fnum + {13'b0, dvs_r[44:1]};

  logic last_node;
  assign last_node = ({1'b0, node_i_r} == nsz_r - CNT_W'(1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_data.func == FUNC_INPUT && in_data.last) begin
          state_nxt = bad ? S_ERR : S_MRD;
        end
      end
      S_MRD:  state_nxt = S_MMUL;
      S_MMUL: state_nxt = S_MACC;
      S_MACC: state_nxt = ({1'b0, j_r} == mcnt_r - CNT_W'(1)) ? S_RND : S_MRD;
      S_RND:  state_nxt = S_TLO;
      S_TLO:  state_nxt = S_THI;
      S_THI:  state_nxt = S_TLD;
      S_TLD:  state_nxt = S_TDIV;
      S_TDIV: state_nxt = (dcnt_r == 6'd1) ? S_TUPD : S_TDIV;
      S_TUPD: state_nxt = (quo_r == 44'd0 || n_r == LAST_TERM) ? S_FDEN : S_TLO;
      S_FDEN: state_nxt = S_FLD;
      S_FLD:  state_nxt = S_FDIV;
      S_FDIV: state_nxt = (dcnt_r == 6'd1) ? S_EMIT : S_FDIV;
      S_EMIT: begin
        if (out_free) begin
          state_nxt = last_node ? S_IDLE : S_MRD;
        end
      end
      S_ERR: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      size0_r     <= 5'd16;
      size1_r     <= 5'd16;
      size2_r     <= 5'd16;
      size3_r     <= 5'd16;
      bias0_r     <= '0;
      bias1_r     <= '0;
      bias2_r     <= '0;
      bias3_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_SIZE0: size0_r <= cfg_wdata[4:0];
          REG_SIZE1: size1_r <= cfg_wdata[4:0];
          REG_SIZE2: size2_r <= cfg_wdata[4:0];
          REG_SIZE3: size3_r <= cfg_wdata[4:0];
          REG_BIAS0: bias0_r <= $signed(cfg_wdata);
          REG_BIAS1: bias1_r <= $signed(cfg_wdata);
          REG_BIAS2: bias2_r <= $signed(cfg_wdata);
          REG_BIAS3: bias3_r <= $signed(cfg_wdata);
          default: ;
        endcase
      end
      if (in_acc && in_data.func == FUNC_INPUT) begin
        if (in_data.last) begin
          cnt_r <= '0;
          ovf_r <= 1'b0;
        end else begin
          cnt_r <= cnt_app;
          ovf_r <= ovf_new;
        end
      end
      if ((state_r == S_EMIT || state_r == S_ERR) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (in_acc && in_data.func == FUNC_WEIGHT) begin
      wmem[{in_data.layer, in_data.src_index, in_data.node_index}] <= in_data.value;
    end
    if (in_acc && in_data.func == FUNC_INPUT && cnt_r < CNT_W'(MAX_NODES)) begin
      ibuf[cnt_r[IDX_W-1:0]] <= in_data.value;
    end
    if (state_r == S_MRD) begin
      wt_rd_r <= wmem[{layer_r, j_r, node_i_r}];
      in_rd_r <= ibuf[j_r];
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        layer_r  <= in_data.layer;
        nsz_r    <= eff_size(sel_size);
        bias_l_r <= sel_bias;
        mcnt_r   <= cnt_app;
        j_r      <= '0;
        node_i_r <= '0;
        acc_r    <= {{10{sel_bias[15]}}, sel_bias, 12'b0};
      end
      S_MMUL: prod_r <= mul_p;
      S_MACC: begin
        acc_r <= acc_r + 38'(prod_r);
        j_r   <= j_r + IDX_W'(1);
      end
      S_RND: begin
        t_r    <= x_mag[15:0];
        neg_r  <= x_sat[15];
        term_r <= 44'd1 << 32;
        e_r    <= 44'd1 << 32;
        n_r    <= 6'd1;
      end
      S_TLO: prod_r <= mul_p;
      S_THI: begin
        big_r  <= prod_r[37:0];
        prod_r <= mul_p;
      end
      S_TLD: begin
        rem_r  <= '0;
        dsh_r  <= tsum[55:12];
        dvs_r  <= {39'b0, n_r};
        dcnt_r <= 6'd44;
      end
      S_TDIV, S_FDIV: begin
        rem_r  <= div_ge ? div_diff[44:0] : {rem_r[43:0], dsh_r[43]};
        dsh_r  <= {dsh_r[42:0], 1'b0};
        quo_r  <= {quo_r[42:0], div_ge};
        dcnt_r <= dcnt_r - 6'd1;
      end
      S_TUPD: begin
        term_r <= quo_r;
        e_r    <= e_r + quo_r;
        n_r    <= n_r + 6'd1;
      end
      S_FDEN: dvs_r <= (45'd1 << 32) + {1'b0, e_r};
      S_FLD: begin
        rem_r  <= {1'b0, fnd[56:13]};
        dsh_r  <= {fnd[12:0], 31'b0};
        dcnt_r <= 6'd13;
      end
      S_EMIT: begin
        if (out_free) begin
          out_data_r.node       <= node_i_r;
          out_data_r.activation <= quo_r[12:0];
          out_data_r.last_out   <= last_node;
          out_data_r.error      <= 1'b0;
          node_i_r <= node_i_r + IDX_W'(1);
          j_r      <= '0;
          acc_r    <= {{10{bias_l_r[15]}}, bias_l_r, 12'b0};
        end
      end
      S_ERR: begin
        if (out_free) begin
          out_data_r.node       <= '0;
          out_data_r.activation <= '0;
          out_data_r.last_out   <= 1'b1;
          out_data_r.error      <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.error |->
      out_data_r.last_out && out_data_r.node == 4'd0 && out_data_r.activation == 13'd0)
    else $error("error word malformed");

  a_act_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.error |-> out_data_r.activation <= 13'd4096)
    else $error("activation above one");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_NODES))
    else $error("input count beyond buffer");

  a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TDIV || state_r == S_FDIV) |-> dcnt_r != 6'd0)
    else $error("divider ran past its count");

endmodule
